@@ rtl/hsic_pkg.sv @@
// Shared types and constants for the hash set insert / chain statistics unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsic_pkg;

  localparam int unsigned BUCKETS      = 2048;
  localparam int unsigned KEY_CAPACITY = 1024;
  localparam int unsigned NUM_CELLS    = 16;
  localparam int unsigned CELL_ROWS    = KEY_CAPACITY / NUM_CELLS;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned HASH_W   = 20;
  localparam int unsigned BKT_W    = $clog2(BUCKETS);
  localparam int unsigned BCNT_W   = 12;
  localparam int unsigned CNT_W    = $clog2(KEY_CAPACITY) + 1;
  localparam int unsigned IDX_W    = $clog2(KEY_CAPACITY);
  localparam int unsigned CID_W    = $clog2(NUM_CELLS);
  localparam int unsigned ROW_W    = $clog2(CELL_ROWS);
  localparam int unsigned COLL_W   = 10;
  localparam int unsigned BITCNT_W = $clog2(KEY_W);
  localparam int unsigned DIVCNT_W = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_PRIME = HASH_W'(999149);

  localparam logic [1:0] REG_MULT  = 2'd0;
  localparam logic [1:0] REG_OFFS  = 2'd1;
  localparam logic [1:0] REG_BCNT  = 2'd2;

  typedef enum logic [1:0] {
    HP_IDLE,
    HP_MUL,
    HP_OFS,
    HP_DIV
  } hash_phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } top_state_e;

  // Broadcast from the sequencer to every cell of the search chain.
  typedef struct packed {
    logic              scan;
    logic [ROW_W-1:0]  row;
    logic              start;
    logic              wr;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  key;
    logic [BKT_W-1:0]  bucket;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/hsic_hash.sv @@
// Iterative hash: ((mult*key + offset) mod prime) mod bucket divisor.
// Depends on hsic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsic_hash import hsic_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [HASH_W-1:0] mult_i,
  input  wire logic [HASH_W-1:0] offs_i,
  input  wire logic [BCNT_W-1:0] bcount_i,
  output logic                   done_o,
  output logic [BKT_W-1:0]       bucket_o
);

  hash_phase_e          phase_q, phase_d;
  logic [BITCNT_W-1:0]  cnt_q;
  logic [KEY_W-1:0]     key_q;
  logic [HASH_W-1:0]    h_q;
  logic [BKT_W-1:0]     rem_q;

  logic [HASH_W-1:0]    m_red, o_red, dbl_r, mul_r, ofs_r;
  logic [HASH_W:0]      dbl, msum, osum;
  logic [BCNT_W-1:0]    div, r_div;
  logic [BKT_W:0]       r;

  // Registers may exceed the prime by less than one prime.
  assign m_red = (mult_i >= HASH_PRIME) ? mult_i - HASH_PRIME : mult_i;
  assign o_red = (offs_i >= HASH_PRIME) ? offs_i - HASH_PRIME : offs_i;

  // One key bit per cycle, MSB first, kept below the prime.
  assign dbl   = {h_q, 1'b0};
  assign dbl_r = (dbl >= {1'b0, HASH_PRIME}) ? HASH_W'(dbl - {1'b0, HASH_PRIME})
                                             : HASH_W'(dbl);
  assign msum  = {1'b0, dbl_r} + (key_q[cnt_q] ? {1'b0, m_red} : '0);
  assign mul_r = (msum >= {1'b0, HASH_PRIME}) ? HASH_W'(msum - {1'b0, HASH_PRIME})
                                              : HASH_W'(msum);
  assign osum  = {1'b0, h_q} + {1'b0, o_red};
  assign ofs_r = (osum >= {1'b0, HASH_PRIME}) ? HASH_W'(osum - {1'b0, HASH_PRIME})
                                              : HASH_W'(osum);

  // Zero divisor acts as one, oversize as the bucket count.
  always_comb begin
    div = bcount_i;
    if (bcount_i == '0) div = BCNT_W'(1);
    if (bcount_i > BCNT_W'(BUCKETS)) div = BCNT_W'(BUCKETS);
  end

  assign r     = {rem_q, h_q[HASH_W-1]};
  assign r_div = ({1'b0, r} >= div) ? BCNT_W'({1'b0, r} - div) : BCNT_W'({1'b0, r});

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      HP_IDLE: if (start_i) phase_d = HP_MUL;
      HP_MUL:  if (cnt_q == '0) phase_d = HP_OFS;
      HP_OFS:  phase_d = HP_DIV;
      HP_DIV:  if (cnt_q == '0) phase_d = HP_IDLE;
      default: phase_d = HP_IDLE;
    endcase
  end

  always_comb begin
    done_o = (phase_q == HP_DIV) && (cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      HP_IDLE: begin
        key_q <= key_i;
        h_q   <= '0;
        cnt_q <= BITCNT_W'(KEY_W - 1);
      end
      HP_MUL: begin
        h_q   <= mul_r;
        cnt_q <= cnt_q - 1'b1;
      end
      HP_OFS: begin
        h_q   <= ofs_r;
        rem_q <= '0;
        cnt_q <= BITCNT_W'(HASH_W - 1);
      end
      HP_DIV: begin
        rem_q <= BKT_W'(r_div);
        h_q   <= {h_q[HASH_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign bucket_o = BKT_W'(r_div);

endmodule
`default_nettype wire

@@ rtl/hsic_cell.sv @@
// One search cell: a bank of stored keys, a local match flag, and a
// registered OR link to the next cell. Depends on hsic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsic_cell import hsic_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CID_W-1:0] cell_id_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic             hit_i,
  output logic                  hit_o
);

  logic [BKT_W+KEY_W-1:0] mem [CELL_ROWS];
  logic [BKT_W+KEY_W-1:0] rd_q;
  logic                   rd_ok_q;
  logic                   local_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       rd_idx;

  assign rd_idx = {ctrl_i.row, cell_id_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr && (ctrl_i.wr_idx[CID_W-1:0] == cell_id_i)) begin
      mem[ctrl_i.wr_idx[IDX_W-1:CID_W]] <= {ctrl_i.bucket, ctrl_i.key};
    end
    rd_q <= mem[ctrl_i.row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
      local_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      // only entries below the fill count are ever compared
      rd_ok_q <= ctrl_i.scan && ({1'b0, rd_idx} < ctrl_i.count);
      if (ctrl_i.start) begin
        local_q <= 1'b0;
      end else if (rd_ok_q && (rd_q == {ctrl_i.bucket, ctrl_i.key})) begin
        local_q <= 1'b1;
      end
      hit_q <= hit_i | local_q;
    end
  end

  assign hit_o = hit_q;

endmodule
`default_nettype wire

@@ rtl/hash_set_insert_chain_stats_unit.sv @@
// Hash set insert unit with chain statistics; top level.
// Depends on hsic_pkg, hsic_hash, hsic_cell.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. After reset the bucket length memory is cleared,
// during which no request is taken (register writes work). Each request then
// goes from acceptance to its result through the bit-serial multiply-mod, the
// offset, the bucket divide, the parallel scan of the 16 key banks (one row
// per cycle) and the drain of the hit chain, then a commit. The next request
// is accepted in the cycle after the commit. A finished result waits in the
// output register while the next request is already accepted; a request that
// finishes while that result is still stalled holds in commit until the
// output frees.
module hash_set_insert_chain_stats_unit import hsic_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [KEY_W-1:0]   key_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [BKT_W-1:0]        bucket_index_o,
  output logic                    was_duplicate_o,
  output logic                    store_full_o,
  output logic [CNT_W-1:0]        distinct_count_o,
  output logic [COLL_W-1:0]       collision_count_o,
  output logic [CNT_W-1:0]        longest_chain_o
);

  localparam int unsigned DRAIN_CYC = NUM_CELLS + 4;
  localparam int unsigned DRN_W     = $clog2(DRAIN_CYC);

  logic [HASH_W-1:0] mult_q, offs_q;
  logic [BCNT_W-1:0] bcnt_q;

  top_state_e        state_q, state_d;
  logic [KEY_W-1:0]  key_q;
  logic [BKT_W-1:0]  bucket_q, hash_bkt;
  logic              hash_start, hash_done;
  logic [ROW_W-1:0]  row_q;
  logic [DRN_W-1:0]  drn_q;
  logic [BKT_W-1:0]  clr_q;
  logic [CNT_W-1:0]  count_q;
  logic [COLL_W-1:0] coll_q;
  logic [CNT_W-1:0]  maxc_q;
  logic [CNT_W-1:0]  blen_rd_q, blen_new;
  logic [CNT_W-1:0]  blen_mem [BUCKETS];
  logic              in_acc, cfg_wr, commit, out_free, dup, full, ins;
  cell_ctrl_t        ctrl;
  logic [NUM_CELLS:0] hit_chain;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= HASH_W'(1);
      offs_q <= '0;
      bcnt_q <= BCNT_W'(BUCKETS);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MULT: mult_q <= pwdata[HASH_W-1:0];
        REG_OFFS: offs_q <= pwdata[HASH_W-1:0];
        REG_BCNT: bcnt_q <= pwdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MULT: prdata = {{(32-HASH_W){1'b0}}, mult_q};
      REG_OFFS: prdata = {{(32-HASH_W){1'b0}}, offs_q};
      REG_BCNT: prdata = {{(32-BCNT_W){1'b0}}, bcnt_q};
      default:  prdata = '0;
    endcase
  end

  hsic_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (key_value_i),
    .mult_i   (mult_q),
    .offs_i   (offs_q),
    .bcount_i (bcnt_q),
    .done_o   (hash_done),
    .bucket_o (hash_bkt)
  );

  assign out_free = !out_valid_o || !out_stall_i;
  assign dup      = hit_chain[NUM_CELLS];
  assign full     = !dup && (count_q >= CNT_W'(KEY_CAPACITY));
  assign blen_new = blen_rd_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_HASH;
      ST_HASH:   if (hash_done) state_d = ST_SCAN;
      ST_SCAN:   if (row_q == '1) state_d = ST_DRAIN;
      ST_DRAIN:  if (drn_q == DRN_W'(DRAIN_CYC - 1)) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_acc     = in_valid_i && (state_q == ST_IDLE);
    hash_start = in_acc;
    commit     = (state_q == ST_COMMIT) && out_free;
    ins        = commit && !dup && !full;
  end

  always_comb begin
    ctrl.scan   = (state_q == ST_SCAN);
    ctrl.row    = row_q;
    ctrl.start  = (state_q == ST_HASH);
    ctrl.wr     = ins;
    ctrl.wr_idx = count_q[IDX_W-1:0];
    ctrl.key    = key_q;
    ctrl.bucket = bucket_q;
    ctrl.count  = count_q;
  end

  assign hit_chain[0] = 1'b0;
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    hsic_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cell_id_i (CID_W'(c)),
      .ctrl_i    (ctrl),
      .hit_i     (hit_chain[c]),
      .hit_o     (hit_chain[c+1])
    );
  end

  // bucket length memory: one write port shared by clearing and commit
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      blen_mem[clr_q] <= '0;
    end else if (ins) begin
      blen_mem[bucket_q] <= blen_new;
    end
    blen_rd_q <= blen_mem[bucket_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) key_q <= key_value_i;
    if (hash_done) bucket_q <= hash_bkt;
    if (commit) begin
      bucket_index_o  <= bucket_q;
      was_duplicate_o <= dup;
      store_full_o    <= full;
      distinct_count_o  <= ins ? count_q + 1'b1 : count_q;
      collision_count_o <= (ins && (blen_rd_q != '0)) ? coll_q + 1'b1 : coll_q;
      longest_chain_o   <= (ins && (blen_new > maxc_q)) ? blen_new : maxc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      row_q       <= '0;
      drn_q       <= '0;
      count_q     <= '0;
      coll_q      <= '0;
      maxc_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      row_q <= (state_q == ST_SCAN) ? row_q + 1'b1 : '0;
      drn_q <= (state_q == ST_DRAIN) ? drn_q + 1'b1 : '0;
      if (ins) begin
        count_q <= count_q + 1'b1;
        if (blen_rd_q != '0) coll_q <= coll_q + 1'b1;
        if (blen_new > maxc_q) maxc_q <= blen_new;
      end
      if (commit) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  a_no_dup_and_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(was_duplicate_o && store_full_o))
    else $error("duplicate and full reported together");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(KEY_CAPACITY))
    else $error("fill count above capacity");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_COMMIT))
    else $error("result appeared without a commit");

  a_chain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    maxc_q <= count_q)
    else $error("longest chain exceeds stored keys");

endmodule
`default_nettype wire
